// File: hdl/kdef_pkg.sv
// ----------------------------------------------------------------------------
// kdef_pkg: shared types and constants for the key debounce event FIFO
// Field widths, operation codes, lane event and push types, event code helper.
// ----------------------------------------------------------------------------
package kdef_pkg;

    // Default sizes handed to the top level
    localparam int KEYS_DEF       = 4;
    localparam int FIFO_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int KEYS_IN_W = 4;   // keys_down bits
    localparam int FT_W      = 7;   // filter_time bits
    localparam int CNT_W     = 8;   // debounce counter bits
    localparam int CODE_W    = 4;   // key_code bits
    localparam int KEY_IDX_W = 4;   // widest key index (up to 16 keys)

    // Reset values
    localparam logic [FT_W-1:0]  FT_RESET    = 7'd5;
    localparam logic [CNT_W-1:0] COUNT_RESET = 8'd2;

    // Operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Event found by one lane on a scan tick
    typedef struct packed {
        logic valid;
        logic press;
    } t_evt;

    // One write into the event store
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } t_push;

    // Event code: 3*key+2 on press, 3*key+1 on release, kept to CODE_W bits
    function automatic logic [CODE_W-1:0] kdef_code(input logic [KEY_IDX_W-1:0] idx,
                                                     input logic press);
        logic [KEY_IDX_W+2:0] sum;
        begin
            sum = ({3'b000, idx} << 1) + {3'b000, idx} + (KEY_IDX_W+3)'(1)
                  + {{(KEY_IDX_W+2){1'b0}}, press};
            return sum[CODE_W-1:0];
        end
    endfunction

endpackage

// File: hdl/kdef_item_if.sv
// ----------------------------------------------------------------------------
// kdef_item_if: input item channel
// Carries the operation and the key levels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kdef_item_if
    import kdef_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [KEYS_IN_W-1:0] keys_down;

    modport source (output valid, output operation, output keys_down, input ready);
    modport sink   (input valid, input operation, input keys_down, output ready);
endinterface

// File: hdl/kdef_result_if.sv
// ----------------------------------------------------------------------------
// kdef_result_if: result item channel
// Carries the popped key code and the empty flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kdef_result_if
    import kdef_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] key_code;
    logic              fifo_empty;

    modport source (output valid, output key_code, output fifo_empty, input ready);
    modport sink   (input valid, input key_code, input fifo_empty, output ready);
endinterface

// File: hdl/kdef_cfg_if.sv
// ----------------------------------------------------------------------------
// kdef_cfg_if: configuration write channel
// Carries the filter time write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kdef_cfg_if
    import kdef_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [FT_W-1:0] filter_time;

    modport source (output valid, output filter_time, input ready);
    modport sink   (input valid, input filter_time, output ready);
endinterface

// File: hdl/key_debounce_event_fifo.sv
// A scan tick holds the input while the lanes register their events and the merge
//   walks the lanes, one per key, into the single store write port.
// A pop's code goes into the store read register, then into the output register once
//   that is free; one item at a time, and a new item only while the merge is idle.
// Reset (synchronous, active low): filter time 5, counts 2, all keys released,
//   store empty; store contents are not cleared.
// ----------------------------------------------------------------------------
// key_debounce_event_fifo: key debounce with an event FIFO
// Parallel debounce lanes, a merge stage and a ring store of key events.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo
    import kdef_pkg::*;
#(
    parameter int KEYS       = KEYS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kdef_item_if.sink   i_item,
    kdef_cfg_if.sink    i_cfg,
    kdef_result_if.source o_result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic              r_state;
    logic [FT_W-1:0]   r_filter_time;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_empty;

    logic              item_acc;
    logic              scan_acc;
    logic              pop_acc;
    logic              merge_busy;
    logic              out_free;
    t_evt              lane_evt [KEYS];
    t_push             push;
    logic [CODE_W-1:0] fifo_code;
    logic              fifo_empty;

    // Handshakes
    assign i_item.ready = (r_state == ST_IDLE) && !merge_busy;
    assign item_acc     = i_item.valid && i_item.ready;
    assign scan_acc     = item_acc && (i_item.operation == OP_SCAN);
    assign pop_acc      = item_acc && (i_item.operation == OP_POP);
    assign i_cfg.ready  = 1'b1;
    assign out_free     = !r_out_valid || o_result.ready;

    // Hold the filter time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_time <= FT_RESET;
        end else if (i_cfg.valid) begin
            r_filter_time <= i_cfg.filter_time;
        end
    end

    // Debounce lanes, one per key; keys without an input bit read released
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        logic down;
        if (k < KEYS_IN_W) begin : g_in
            assign down = i_item.keys_down[k];
        end else begin : g_none
            assign down = 1'b0;
        end
        kdef_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_strobe      (scan_acc),
            .i_down        (down),
            .i_filter_time (r_filter_time),
            .o_evt         (lane_evt[k])
        );
    end

    kdef_merge #(
        .KEYS (KEYS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_acc),
        .i_evt   (lane_evt),
        .o_push  (push),
        .o_busy  (merge_busy)
    );

    kdef_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop_acc),
        .o_code  (fifo_code),
        .o_empty (fifo_empty)
    );

    // Pop sequencing and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (pop_acc) begin
                        r_state <= ST_RESP;
                    end
                    if (o_result.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Load the result item
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RESP) && out_free) begin
            r_out_code  <= fifo_code;
            r_out_empty <= fifo_empty;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.key_code   = r_out_code;
    assign o_result.fifo_empty = r_out_empty;

endmodule

// File: hdl/kdef_lane.sv
// ----------------------------------------------------------------------------
// kdef_lane: debounce lane for one key
// Hysteresis counter and pressed flag; flags a press or release event per scan.
// ----------------------------------------------------------------------------
module kdef_lane
    import kdef_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_strobe,
    input  logic            i_down,
    input  logic [FT_W-1:0] i_filter_time,
    output t_evt            o_evt
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pressed, n_pressed;
    t_evt             r_evt, n_evt;
    logic [CNT_W-1:0] ft1, ft2;

    assign ft1 = {1'b0, i_filter_time};
    assign ft2 = {i_filter_time, 1'b0};

    // Work out next count, pressed flag and event
    always_comb begin
        n_count     = r_count;
        n_pressed   = r_pressed;
        n_evt.valid = 1'b0;
        n_evt.press = i_down;
        if (i_down) begin
            if (r_count < ft1) begin
                n_count = ft1;
            end else if (r_count < ft2) begin
                n_count = r_count + CNT_W'(1);
            end else if (!r_pressed) begin
                n_pressed   = 1'b1;
                n_evt.valid = 1'b1;
            end
        end else begin
            if (r_count > ft1) begin
                n_count = ft1;
            end else if (r_count != '0) begin
                n_count = r_count - CNT_W'(1);
            end else if (r_pressed) begin
                n_pressed   = 1'b0;
                n_evt.valid = 1'b1;
            end
        end
    end

    // Update on each scan tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_pressed   <= 1'b0;
            r_evt.valid <= 1'b0;
        end else if (i_strobe) begin
            r_count     <= n_count;
            r_pressed   <= n_pressed;
            r_evt.valid <= n_evt.valid;
        end
    end

    // Payload bit needs no reset
    always_ff @(posedge i_clk) begin
        if (i_strobe) begin
            r_evt.press <= n_evt.press;
        end
    end

    assign o_evt = r_evt;

endmodule

// File: hdl/kdef_merge.sv
// ----------------------------------------------------------------------------
// kdef_merge: lane merge
// Walks the lane events in key order, one key a cycle, and issues pushes.
// ----------------------------------------------------------------------------
module kdef_merge
    import kdef_pkg::*;
#(
    parameter int KEYS = KEYS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_evt  i_evt [KEYS],
    output t_push o_push,
    output logic  o_busy
);

    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEYS - 1);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;

    // Advance through the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (r_idx == IDX_LAST) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Push the current lane's event
    assign o_push.valid = r_busy && i_evt[r_idx].valid;
    assign o_push.code  = kdef_code(KEY_IDX_W'(r_idx), i_evt[r_idx].press);
    assign o_busy       = r_busy;

endmodule

// File: hdl/kdef_fifo.sv
// ----------------------------------------------------------------------------
// kdef_fifo: ring event store
// One write and one registered read per cycle; no full check, overflow overwrites.
// ----------------------------------------------------------------------------
module kdef_fifo
    import kdef_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    input  logic              i_pop,
    output logic [CODE_W-1:0] o_code,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [CODE_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CODE_W-1:0] r_code;
    logic              r_empty;
    logic              empty_now;

    assign empty_now = (r_rd_ptr == r_wr_ptr);

    // Store write
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            mem[r_wr_ptr] <= i_push.code;
        end
    end

    // Store read
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_code <= empty_now ? '0 : mem[r_rd_ptr];
        end
    end

    // Pointers and empty flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_empty  <= 1'b1;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_empty <= empty_now;
                if (!empty_now) begin
                    r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
                end
            end
        end
    end

    assign o_code  = r_code;
    assign o_empty = r_empty;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for key_debounce_event_fifo
// Drives scan ticks and pops through the item channel, keeps its own
// debounce and event ring model, and checks every popped item in order.
// The sender idles in bursts and the receiver stalls on a rotating mask.
// ----------------------------------------------------------------------------
module tb_top;
    import kdef_pkg::*;

    localparam int KEYS          = KEYS_DEF;
    localparam int FIFO_DEPTH    = FIFO_DEPTH_DEF;
    localparam int SETTLE_CYCLES = KEYS + 4;
    localparam int RUN_LIMIT     = 5000000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              fifo_empty;
    } t_pop_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kdef_item_if   item_ch ();
    kdef_cfg_if    cfg_ch ();
    kdef_result_if result_ch ();

    key_debounce_event_fifo i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    // Debounce and event ring model
    logic [FT_W-1:0]   ft_now;
    logic [CNT_W-1:0]  tick_count [KEYS];
    logic              key_held [KEYS];
    logic [CODE_W-1:0] event_ring [FIFO_DEPTH];
    int                ring_rd;
    int                ring_wr;

    t_pop_result expected_pops [$];
    int          error_count = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          gap_limit   = 0;

    always #6 i_clk = ~i_clk;

    // Push one event code into the ring, overwriting on overflow
    task automatic ring_push(input int code);
        event_ring[ring_wr] = CODE_W'(code);
        ring_wr = (ring_wr + 1) % FIFO_DEPTH;
    endtask

    // Advance every key counter by one scan tick, in key order
    task automatic apply_scan_tick(input logic [KEYS_IN_W-1:0] levels);
        int unsigned c;
        int unsigned ft;
        logic        down;
        ft = ft_now;
        for (int k = 0; k < KEYS; k++) begin
            c = tick_count[k];
            down = (k < KEYS_IN_W) ? levels[k] : 1'b0;
            if (down) begin
                if (c < ft) begin
                    c = ft;
                end else if (c < 2 * ft) begin
                    c = c + 1;
                end else if (!key_held[k]) begin
                    key_held[k] = 1'b1;
                    ring_push(3 * k + 2);
                end
            end else begin
                if (c > ft) begin
                    c = ft;
                end else if (c != 0) begin
                    c = c - 1;
                end else if (key_held[k]) begin
                    key_held[k] = 1'b0;
                    ring_push(3 * k + 1);
                end
            end
            tick_count[k] = CNT_W'(c);
        end
    endtask

    // Work out the item a pop returns and queue it
    task automatic take_event();
        t_pop_result want;
        if (ring_rd == ring_wr) begin
            want.key_code   = '0;
            want.fifo_empty = 1'b1;
        end else begin
            want.key_code   = event_ring[ring_rd];
            want.fifo_empty = 1'b0;
            ring_rd = (ring_rd + 1) % FIFO_DEPTH;
        end
        expected_pops.push_back(want);
    endtask

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endtask

    // Send one item, idling between bursts, and update the model on acceptance
    task automatic send_item(input logic op, input logic [KEYS_IN_W-1:0] levels);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_limit == 0 || $urandom_range(0, 3) == 0) ? 0
                                                              : $urandom_range(1, gap_limit);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.keys_down <= levels;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
        if (op == OP_POP)
            take_event();
        else
            apply_scan_tick(levels);
    endtask

    task automatic scan(input logic [KEYS_IN_W-1:0] levels);
        send_item(OP_SCAN, levels);
    endtask

    // Key levels are ignored on a pop, so drive noise there
    task automatic pop_key();
        send_item(OP_POP, KEYS_IN_W'($urandom));
    endtask

    // Hold the sender until every pop has returned and the scan pipeline is quiet
    task automatic drain_and_settle();
        item_ch.valid <= 1'b0;
        while (expected_pops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_filter_time(input logic [FT_W-1:0] value);
        drain_and_settle();
        cfg_ch.filter_time <= value;
        cfg_ch.valid       <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        ft_now = value;
    endtask

    // Pops on an empty store straight after reset, and releases with no press
    task automatic test_empty_after_reset();
        gap_limit = 3;
        pop_key();
        scan('0);
        scan('0);
        pop_key();
    endtask

    // Filter time 1: single keys in both halves, press and release codes
    task automatic test_single_keys();
        write_filter_time(FT_W'(1));
        scan(KEYS_IN_W'(4'h5));
        repeat (4) scan(KEYS_IN_W'(4'hA));
        repeat (6) pop_key();
    endtask

    // Zero filter: events at once, more than the ring holds, so it wraps and overwrites unread events
    task automatic test_overflow();
        write_filter_time(FT_W'(0));
        repeat (3) begin
            scan(KEYS_IN_W'(4'hF));
            scan('0);
        end
        repeat (3) pop_key();
    endtask

    // Mostly held key patterns long enough to debounce, with glitches and pop runs
    task automatic test_random_phase(input logic [FT_W-1:0] ft, input int n_items,
                                     input int gap_max);
        int                   first_item;
        int                   hold;
        int                   ft_i;
        logic [KEYS_IN_W-1:0] pattern;
        write_filter_time(ft);
        gap_limit  = gap_max;
        first_item = items_sent;
        ft_i       = ft;
        while (items_sent - first_item < n_items) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6)) scan(KEYS_IN_W'($urandom));
                1: repeat ($urandom_range(1, 10)) pop_key();
                default: begin
                    pattern = KEYS_IN_W'($urandom);
                    hold = ($urandom_range(0, 4) < 3) ? $urandom_range(ft_i + 2, 2 * ft_i + 4)
                                                      : $urandom_range(1, ft_i + 1);
                    repeat (hold) begin
                        if ($urandom_range(0, 5) == 0)
                            pop_key();
                        scan(pattern);
                    end
                end
            endcase
        end
    endtask

    // Check each popped item against the oldest expectation
    always @(posedge i_clk) begin
        t_pop_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_pops.size() == 0) begin
                note_error($sformatf("unexpected item: code %0d empty %0b",
                                     result_ch.key_code, result_ch.fifo_empty));
            end else begin
                want = expected_pops.pop_front();
                if (result_ch.key_code !== want.key_code)
                    note_error($sformatf("key_code mismatch: expected %0d, got %0d",
                                         want.key_code, result_ch.key_code));
                if (result_ch.fifo_empty !== want.fifo_empty)
                    note_error($sformatf("fifo_empty mismatch: expected %0b, got %0b",
                                         want.fifo_empty, result_ch.fifo_empty));
            end
        end
    end

    // Receiver: ready follows a rotating random mask that is redrawn periodically
    initial begin
        logic [15:0] ready_mask;
        int          cyc;
        ready_mask = 16'hFFFF;
        cyc        = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cyc % 64 == 0)
                ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            result_ch.ready <= ready_mask[cyc % 16];
            cyc++;
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.operation  <= OP_SCAN;
        item_ch.keys_down  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.filter_time <= FT_RESET;

        // Model reset state
        ft_now  = FT_RESET;
        ring_rd = 0;
        ring_wr = 0;
        for (int k = 0; k < KEYS; k++) begin
            tick_count[k] = COUNT_RESET;
            key_held[k]   = 1'b0;
        end
        for (int i = 0; i < FIFO_DEPTH; i++)
            event_ring[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_after_reset();
        test_single_keys();
        test_overflow();
        test_random_phase(FT_W'(3), 220, 4);
        test_random_phase(FT_W'(127), 300, 2);
        test_random_phase(FT_W'(2), 200, 8);
        test_random_phase(FT_W'(0), 100, 0);
        test_random_phase(FT_W'($urandom_range(4, 12)), 250, 6);
        test_random_phase(FT_W'(1), 150, 3);

        drain_and_settle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
